@@ src/tcw_pkg.sv @@
// Shared constants and types of the text console writer.
`default_nettype none
package tcw_pkg;

  // Field widths fixed by the item formats.
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COLIN_W  = 7;
  localparam int CELLIN_W = 11;
  localparam int CURSOR_W = 11;
  localparam int WORD_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_CONSOLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STATUS  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

  // Console control and character codes.
  localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;
  localparam int TAB_STEP = 8;

  // Register indexes and reset colors.
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_ATTR = 1'd1;
  localparam logic [ATTR_W-1:0] RESET_TEXT_ATTR   = 8'h0F;
  localparam logic [ATTR_W-1:0] RESET_STATUS_ATTR = 8'h1F;

  // Controller states.
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

@@ src/tcw_if.sv @@
// Handshake channels for input items and result items.
`default_nettype none
interface tcw_in_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]   char_code;
  logic [COLIN_W-1:0]  column;
  logic [CELLIN_W-1:0] cell_index;
  modport source (output valid, action, char_code, column, cell_index, input ready);
  modport sink   (input valid, action, char_code, column, cell_index, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_index;
  logic [WORD_W-1:0]   read_data;
  logic                scrolled;
  modport source (output valid, cursor_index, read_data, scrolled, input ready);
  modport sink   (input valid, cursor_index, read_data, scrolled, output ready);
endinterface
`default_nettype wire

@@ src/tcw_screen_ram.sv @@
// Screen cell memory with one write port and one registered read port.
`default_nettype none
module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [tcw_pkg::WORD_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr,
  output      logic [tcw_pkg::WORD_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/text_console_writer.sv @@
// Top level of the text console writer: controller, cursor and result register.
// A result goes from the execute state into a pending register, then into the output register when it is free.
// A new item is taken only in the idle state; the accept cycle issues the registered RAM read
// and the execute cycle writes the cell and updates the cursor.
// A character that moves the cursor past the last row starts a scroll of the console rows,
// one cell copied or blanked per cycle through the RAM's read and write ports.
// Reset: synchronous; afterwards a clearing pass fills the screen.
`default_nettype none
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_data,
  tcw_in_if.sink                            items,
  tcw_out_if.source                         results
);
  import tcw_pkg::*;

  // Derived sizes. The column counter has room for COLUMNS, though the cursor wraps on the step sum,
  // and the tab sum can overshoot by up to one tab stop.
  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SRC_W  = $clog2(CELLS + COLUMNS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int TAB_W  = $clog2(COLUMNS + TAB_STEP);
  localparam int ROW_W  = $clog2(ROWS + 1);

  // Configuration registers. Writes are taken in any state.
  logic [ATTR_W-1:0] text_attr;
  logic [ATTR_W-1:0] status_attr;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr   <= RESET_TEXT_ATTR;
      status_attr <= RESET_STATUS_ATTR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_ATTR:   text_attr   <= cfg_data;
        REG_STATUS_ATTR: status_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Controller state, cursor, and the registered copy of the accepted item.
  state_t              state;
  logic [ADDR_W-1:0]   sweep;       // clear address, then scroll destination
  logic [COL_W-1:0]    cursor_col;
  logic [ROW_W-1:0]    cursor_row;
  logic [ACTION_W-1:0] act_q;
  logic [CHAR_W-1:0]   ch_q;
  logic [COLIN_W-1:0]  col_in_q;
  logic [CELLIN_W-1:0] cell_q;

  // Scroll write stage: the cell read in the previous cycle is written one row higher.
  logic                scr_pend;
  logic [ADDR_W-1:0]   scr_waddr;
  logic                scr_from_mem;

  // Result waiting for the output register, and the output register itself.
  logic                res_pend;
  logic [CURSOR_W-1:0] res_cursor;
  logic [WORD_W-1:0]   res_data;
  logic                res_scrolled;
  logic                out_valid;
  logic                out_free;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The output slot frees up this cycle when it is empty or its beat completes.
  // A result still waiting in the slot does not hold off the next item: it sits in the
  // output register while the next one is worked on in the pending register.
  assign out_free    = !out_valid || results.ready;
  assign items.ready = (state == ST_IDLE) && (!res_pend || out_free);

  logic accept;
  assign accept = items.valid && items.ready;

  // Cursor step for a console character. The cursor advances by at most one row, so a
  // row count equal to ROWS is the only case that needs a scroll.
  logic [TAB_W-1:0]  col_t;
  logic [ROW_W-1:0]  row_t;
  logic              wr_char;
  logic              need_scroll;
  logic [ROW_W-1:0]  row_fin;
  logic [COL_W-1:0]  col_fin;
  logic              is_console;

  always_comb begin
    col_t   = TAB_W'(cursor_col);
    row_t   = cursor_row;
    wr_char = 1'b0;
    case (ch_q)
      CH_BS: begin
        if (cursor_col != '0) begin
          col_t = TAB_W'(cursor_col) - TAB_W'(1);
        end
      end
      CH_TAB: begin
        col_t = (TAB_W'(cursor_col) + TAB_W'(TAB_STEP)) & ~TAB_W'(TAB_STEP - 1);
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_LF: begin
        col_t = '0;
        row_t = cursor_row + ROW_W'(1);
      end
      default: begin
        // Printable characters only; the upper half of the code space is dropped.
        if (ch_q >= CH_SPACE && ch_q <= CH_PRINT_LAST) begin
          wr_char = 1'b1;
          col_t   = TAB_W'(cursor_col) + TAB_W'(1);
        end
      end
    endcase
    if (col_t >= TAB_W'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + ROW_W'(1);
    end
  end

  assign is_console  = (act_q == ACT_CONSOLE);
  assign need_scroll = is_console && (row_t == ROW_W'(ROWS));
  assign row_fin     = !is_console ? cursor_row
                     : (need_scroll ? ROW_W'(ROWS - 1) : row_t);
  assign col_fin     = is_console ? COL_W'(col_t) : cursor_col;

  // Linear cursor positions: before the step for the character write, after it for the
  // result.
  logic [ADDR_W-1:0]   cur_addr;
  logic [CURSOR_W-1:0] cursor_next;
  assign cur_addr    = ADDR_W'(cursor_row * COLUMNS + cursor_col);
  assign cursor_next = CURSOR_W'(row_fin * COLUMNS + col_fin);

  // Read data for a read action; an index past the screen reads as zero.
  logic [WORD_W-1:0] read_word;
  always_comb begin
    read_word = '0;
    if (act_q == ACT_READ && cell_q < CELLS) begin
      read_word = ram_rdata;
    end
  end

  // Scroll source: one row below the destination. Past the end the row is blanked.
  logic [SRC_W-1:0] scr_src;
  logic             scr_src_ok;
  assign scr_src    = SRC_W'(sweep) + SRC_W'(COLUMNS);
  assign scr_src_ok = (scr_src < SRC_W'(CELLS));

  // RAM port selection. Each state owns the ports, so no two accesses collide; during a
  // scroll the read runs ahead of the write, and every read address lies above every
  // address written so far.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        ram_wdata = (sweep < ADDR_W'(COLUMNS)) ? {RESET_STATUS_ATTR, CH_SPACE}
                                               : {RESET_TEXT_ATTR, CH_SPACE};
      end
      ST_IDLE: begin
        // The read for a read action is issued as the item is taken.
        ram_re    = accept;
        ram_raddr = ADDR_W'(items.cell_index);
      end
      ST_EXEC: begin
        unique case (act_q)
          ACT_CONSOLE: begin
            ram_we    = wr_char;
            ram_waddr = cur_addr;
            ram_wdata = {text_attr, ch_q};
          end
          ACT_STATUS: begin
            ram_we    = (col_in_q < COLUMNS);
            ram_waddr = ADDR_W'(col_in_q);
            ram_wdata = {status_attr, ch_q};
          end
          default: ;
        endcase
      end
      ST_SCROLL: begin
        ram_re    = scr_src_ok;
        ram_raddr = ADDR_W'(scr_src);
        ram_we    = scr_pend;
        ram_waddr = scr_waddr;
        ram_wdata = scr_from_mem ? ram_rdata : {text_attr, CH_SPACE};
      end
      ST_FLUSH: begin
        ram_we    = scr_pend;
        ram_waddr = scr_waddr;
        ram_wdata = scr_from_mem ? ram_rdata : {text_attr, CH_SPACE};
      end
      default: ;
    endcase
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep      <= '0;
      cursor_col <= '0;
      cursor_row <= ROW_W'(1);
      scr_pend   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sweep == ADDR_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
          sweep <= sweep + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cursor_col <= col_fin;
          cursor_row <= row_fin;
          if (need_scroll) begin
            state <= ST_SCROLL;
            sweep <= ADDR_W'(COLUMNS);
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCROLL: begin
          scr_pend <= 1'b1;
          if (sweep == ADDR_W'(CELLS - 1)) begin
            state <= ST_FLUSH;
          end
          sweep <= sweep + ADDR_W'(1);
        end
        ST_FLUSH: begin
          scr_pend <= 1'b0;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: the accepted item and the scroll write stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q    <= items.action;
      ch_q     <= items.char_code;
      col_in_q <= items.column;
      cell_q   <= items.cell_index;
    end
    if (state == ST_SCROLL) begin
      scr_waddr    <= sweep;
      scr_from_mem <= scr_src_ok;
    end
  end

  // Result path. The result is formed at the end of the item's work and then moves into
  // the output register as soon as that register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_pend && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_EXEC && !need_scroll) || state == ST_FLUSH) begin
        res_pend <= 1'b1;
      end else if (out_free) begin
        res_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      res_cursor   <= cursor_next;
      res_data     <= read_word;
      res_scrolled <= need_scroll;
    end
    if (res_pend && out_free) begin
      results.cursor_index <= res_cursor;
      results.read_data    <= res_data;
      results.scrolled     <= res_scrolled;
    end
  end

  assign results.valid = out_valid;

  // The pending result is always empty when a new result is formed.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EXEC && !need_scroll) || state == ST_FLUSH) |-> !res_pend)
    else $error("pending result overwritten");

  // The cursor stays inside the console rows, below the status row.
  a_cursor_rows: assert property (@(posedge clk) disable iff (rst)
    (cursor_row != '0) && (cursor_row < ROW_W'(ROWS)) && (cursor_col < COL_W'(COLUMNS)))
    else $error("cursor left the console area");

  // Scroll copies never touch the status row.
  a_scroll_keeps_status: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCROLL || state == ST_FLUSH) && scr_pend) |-> (scr_waddr >= ADDR_W'(COLUMNS)))
    else $error("scroll wrote into the status row");

  // A scroll runs only right after a console character was worked on.
  a_scroll_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_SCROLL) |-> ($past(state) == ST_EXEC && $past(act_q) == ACT_CONSOLE))
    else $error("scroll started without a console character");

endmodule
`default_nettype wire
